@@ rtl/core/sps_pkg.sv @@
// shared types, constants and codes of the sparse point smoother sweep unit
package sps_pkg;

   localparam int MAX_ROWS     = 1024;
   localparam int MAX_NZ       = 8192;
   localparam int ROW_W        = $clog2(MAX_ROWS);
   localparam int ROWS_W       = $clog2(MAX_ROWS + 1);
   localparam int NZ_W         = $clog2(MAX_NZ);
   localparam int CNT_W        = $clog2(MAX_NZ + 1);

   // functions of an input transaction
   localparam logic [2:0] FN_LOAD      = 3'd0;
   localparam logic [2:0] FN_WRITE_RHS = 3'd1;
   localparam logic [2:0] FN_WRITE_SOL = 3'd2;
   localparam logic [2:0] FN_SWEEP     = 3'd3;
   localparam logic [2:0] FN_READ_SOL  = 3'd4;
   localparam logic [2:0] FN_CLEAR     = 3'd5;

   // status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_FULL      = 3'd1;
   localparam logic [2:0] ST_ZERO_DIAG = 3'd2;
   localparam logic [2:0] ST_RANGE     = 3'd3;
   localparam logic [2:0] ST_ORDER     = 3'd4;

   // smoother modes
   localparam logic [1:0] MODE_RICH    = 2'd0;
   localparam logic [1:0] MODE_JACOBI  = 2'd1;
   localparam logic [1:0] MODE_GS_FWD  = 2'd2;
   localparam logic [1:0] MODE_GS_REV  = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_MODE     = 2'd0;
   localparam logic [1:0] CSR_DAMPING  = 2'd1;
   localparam logic [1:0] CSR_ROWS     = 2'd2;

   typedef struct packed {
      logic [2:0]         func;
      logic [9:0]         row_index;
      logic [9:0]         col_index;
      logic signed [31:0] value;
   } sps_req_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic [2:0]         status;
   } sps_rsp_type;

   typedef struct packed {
      logic               ent_we;
      logic [NZ_W-1:0]    ent_waddr;
      logic signed [31:0] ent_wvalue;
      logic [ROW_W-1:0]   ent_wcol;
      logic [NZ_W-1:0]    ent_raddr;
      logic               rs_we;
      logic [ROW_W-1:0]   rs_waddr;
      logic [CNT_W-1:0]   rs_wdata;
      logic [ROW_W-1:0]   rs_raddr;
   } sps_mat_cmd_type;

   typedef struct packed {
      logic               sol_we;
      logic               rhs_we;
      logic               corr_we;
      logic [ROW_W-1:0]   waddr;
      logic signed [31:0] wdata;
      logic [ROW_W-1:0]   sol_raddr;
      logic [ROW_W-1:0]   aux_raddr;
   } sps_vec_cmd_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_FILL,
      S_READ,
      S_RESP,
      SW_ROW,
      SW_LO,
      SW_HI,
      SW_RUN,
      SW_RES,
      SW_DEC,
      SW_ACT,
      SW_DIV,
      SW_XI,
      SW_MUL,
      SW_COR,
      SW_NEXT,
      SW_UPA,
      SW_UPB
   } sps_state_type;

endpackage

@@ rtl/core/sps_div.sv @@
// radix-2 restoring divider, 64-bit magnitude by 32-bit magnitude, saturated signed result
module sps_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [63:0]        dividend_mag,
   input  logic [31:0]        divisor_mag,
   input  logic               negate,
   output logic               done,
   output logic signed [31:0] quotient
);

   logic [31:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [31:0] dv_ff, dv_in;
   logic        neg_ff, neg_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dv_in   = dv_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      trial   = {rem_ff, quo_ff[63]};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend_mag;
         dv_in   = divisor_mag;
         neg_in  = negate;
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dv_ff}) begin
            rem_in = 32'(trial - {1'b0, dv_ff});
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dv_ff  <= dv_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_comb begin
      if (!neg_ff) begin
         quotient = (quo_ff > 64'h0000_0000_7FFF_FFFF) ? 32'sh7FFF_FFFF
                                                      : $signed(quo_ff[31:0]);
      end else begin
         quotient = (quo_ff >= 64'h0000_0000_8000_0000) ? 32'sh8000_0000
                                                       : $signed(32'(0 - quo_ff[31:0]));
      end
   end

   assign done = done_ff;

endmodule

@@ rtl/core/sps_mat_store.sv @@
// nonzero store (value and column) and row start offsets
module sps_mat_store (
   input  logic                        clock,
   input  sps_pkg::sps_mat_cmd_type    cmd,
   output logic signed [31:0]          ent_value_q,
   output logic [sps_pkg::ROW_W-1:0]   ent_col_q,
   output logic [sps_pkg::CNT_W-1:0]   rs_q
);

   logic signed [31:0]        ent_value_mem [sps_pkg::MAX_NZ];
   logic [sps_pkg::ROW_W-1:0] ent_col_mem   [sps_pkg::MAX_NZ];
   logic [sps_pkg::CNT_W-1:0] rs_mem        [sps_pkg::MAX_ROWS];

   always_ff @(posedge clock) begin
      if (cmd.ent_we) begin
         ent_value_mem[cmd.ent_waddr] <= cmd.ent_wvalue;
         ent_col_mem[cmd.ent_waddr]   <= cmd.ent_wcol;
      end
      ent_value_q <= ent_value_mem[cmd.ent_raddr];
      ent_col_q   <= ent_col_mem[cmd.ent_raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.rs_we) begin
         rs_mem[cmd.rs_waddr] <= cmd.rs_wdata;
      end
      rs_q <= rs_mem[cmd.rs_raddr];
   end

endmodule

@@ rtl/core/sps_vec_store.sv @@
// solution, right-hand side and correction vectors with a clearing pass after reset
module sps_vec_store (
   input  logic                     clock,
   input  logic                     reset,
   input  sps_pkg::sps_vec_cmd_type cmd,
   output logic signed [31:0]       sol_q,
   output logic signed [31:0]       rhs_q,
   output logic signed [31:0]       corr_q,
   output logic                     busy
);

   logic signed [31:0] sol_mem  [sps_pkg::MAX_ROWS];
   logic signed [31:0] rhs_mem  [sps_pkg::MAX_ROWS];
   logic signed [31:0] corr_mem [sps_pkg::MAX_ROWS];

   logic [sps_pkg::ROWS_W-1:0] clr_ff, clr_in;
   logic                       sol_we, rhs_we;
   logic [sps_pkg::ROW_W-1:0]  waddr;
   logic signed [31:0]         wdata;

   assign busy = (clr_ff != sps_pkg::ROWS_W'(sps_pkg::MAX_ROWS));

   always_comb begin
      clr_in = busy ? clr_ff + 1'b1 : clr_ff;
      if (busy) begin
         sol_we = 1'b1;
         rhs_we = 1'b1;
         waddr  = clr_ff[sps_pkg::ROW_W-1:0];
         wdata  = '0;
      end else begin
         sol_we = cmd.sol_we;
         rhs_we = cmd.rhs_we;
         waddr  = cmd.waddr;
         wdata  = cmd.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (sol_we) begin
         sol_mem[waddr] <= wdata;
      end
      if (rhs_we) begin
         rhs_mem[waddr] <= wdata;
      end
      if (cmd.corr_we && !busy) begin
         corr_mem[waddr] <= wdata;
      end
      sol_q  <= sol_mem[cmd.sol_raddr];
      rhs_q  <= rhs_mem[cmd.aux_raddr];
      corr_q <= corr_mem[cmd.aux_raddr];
   end

endmodule

@@ rtl/core/sparse_point_smoother_sweep_unit.sv @@
// top level: sequencer of the sparse point smoother sweep unit
//
//  channel | direction | handshake          | payload
//  req_    | in        | req_valid/req_stall | sps_req_type
//  rsp_    | out       | rsp_valid/rsp_stall | sps_rsp_type
//  csr_    | in        | csr_valid/csr_ready | csr_index, csr_wdata
//
// a load that skips rows also writes the start offset of every row it opens, and a read
// fetches the solution before its response; a sweep reads per row its stored nonzeros,
// uses the divider in jacobi and gauss-seidel modes for rows with a nonzero diagonal, and
// in richardson and jacobi ends with an update pass over all rows.
// after reset a clearing pass zeroes the solution and right-hand side vectors; no
// transaction is taken meanwhile. the result sits in an output register, so a stalled
// result holds only the next transaction's finish, not its acceptance.
module sparse_point_smoother_sweep_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  sps_pkg::sps_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output sps_pkg::sps_rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [31:0]          csr_wdata
);

   localparam int ROW_W  = sps_pkg::ROW_W;
   localparam int ROWS_W = sps_pkg::ROWS_W;
   localparam int NZ_W   = sps_pkg::NZ_W;
   localparam int CNT_W  = sps_pkg::CNT_W;

   function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
         return a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
      end
      return s;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end
      if (v < -64'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   // configuration
   logic [1:0]        mode_ff;
   logic [17:0]       damp_ff;
   logic [10:0]       rows_ff;
   logic [ROWS_W-1:0] n_act;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= sps_pkg::MODE_GS_FWD;
         damp_ff <= 18'd65536;
         rows_ff <= 11'd1024;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            sps_pkg::CSR_MODE:    mode_ff <= csr_wdata[1:0];
            sps_pkg::CSR_DAMPING: damp_ff <= csr_wdata[17:0];
            sps_pkg::CSR_ROWS:    rows_ff <= csr_wdata[10:0];
            default:              ;
         endcase
      end
   end

   always_comb begin
      if (rows_ff == '0) begin
         n_act = ROWS_W'(1);
      end else if (ROWS_W'(rows_ff) > ROWS_W'(sps_pkg::MAX_ROWS)) begin
         n_act = ROWS_W'(sps_pkg::MAX_ROWS);
      end else begin
         n_act = ROWS_W'(rows_ff);
      end
   end

   // stores
   sps_pkg::sps_mat_cmd_type mat_cmd;
   sps_pkg::sps_vec_cmd_type vec_cmd;
   logic signed [31:0]       ent_value_q;
   logic [ROW_W-1:0]         ent_col_q;
   logic [CNT_W-1:0]         rs_q;
   logic signed [31:0]       sol_q, rhs_q, corr_q;
   logic                     vec_busy;

   sps_mat_store u_mat (
      .clock       (clock),
      .cmd         (mat_cmd),
      .ent_value_q (ent_value_q),
      .ent_col_q   (ent_col_q),
      .rs_q        (rs_q)
   );

   sps_vec_store u_vec (
      .clock  (clock),
      .reset  (reset),
      .cmd    (vec_cmd),
      .sol_q  (sol_q),
      .rhs_q  (rhs_q),
      .corr_q (corr_q),
      .busy   (vec_busy)
   );

   // divider
   logic               div_start;
   logic [63:0]        div_mag;
   logic [31:0]        div_dmag;
   logic               div_neg;
   logic               div_done;
   logic signed [31:0] div_q;

   sps_div u_div (
      .clock        (clock),
      .reset        (reset),
      .start        (div_start),
      .dividend_mag (div_mag),
      .divisor_mag  (div_dmag),
      .negate       (div_neg),
      .done         (div_done),
      .quotient     (div_q)
   );

   // control and datapath registers
   sps_pkg::sps_state_type state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [ROW_W-1:0]   last_ff, last_in;
   logic [ROW_W-1:0]   fptr_ff, fptr_in;
   logic [ROW_W-1:0]   fend_ff, fend_in;
   logic [CNT_W-1:0]   fval_ff, fval_in;
   logic [2:0]         st_ff, st_in;
   logic signed [31:0] rd_ff, rd_in;
   logic               rsp_valid_ff, rsp_valid_in;
   sps_pkg::sps_rsp_type rsp_data_ff, rsp_data_in;

   logic [ROWS_W-1:0]  s_ff, s_in;
   logic [ROW_W-1:0]   i_ff, i_in;
   logic [ROW_W-1:0]   i_sel;
   logic [CNT_W-1:0]   lo_ff, lo_in;
   logic [CNT_W-1:0]   hi_ff, hi_in;
   logic [CNT_W-1:0]   k_ff, k_in;
   logic [CNT_W-1:0]   hi_c;
   logic signed [31:0] rhsi_ff, rhsi_in;
   logic               v1_ff, v1_in, v2_ff, v3_ff;
   logic signed [31:0] a1_ff, a2_ff;
   logic               d1_ff, d2_ff;
   logic signed [63:0] prod_ff;
   logic signed [63:0] acc_ff, acc_in;
   logic signed [47:0] dsum_ff, dsum_in;
   logic signed [63:0] nacc_ff, nacc_in;
   logic signed [31:0] diag_ff, diag_in;
   logic signed [63:0] r_ff, r_in;
   logic signed [31:0] qq_ff, qq_in;
   logic signed [50:0] t_ff;
   logic               issue;
   logic               accept;
   logic               rsp_free;
   logic               in_range;

   assign accept   = req_valid && !req_stall;
   assign req_stall = !(state_ff == sps_pkg::S_IDLE && !vec_busy);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign in_range = {1'b0, req_data.row_index} < n_act;
   assign issue    = k_ff < hi_ff;
   assign i_sel    = (mode_ff == sps_pkg::MODE_GS_REV)
                   ? ROW_W'(n_act - ROWS_W'(1) - s_ff) : s_ff[ROW_W-1:0];
   assign div_mag  = r_ff[63] ? 64'(0 - r_ff) : r_ff;
   assign div_dmag = diag_ff[31] ? 32'(0 - diag_ff) : diag_ff;
   assign div_neg  = r_ff[63] ^ diag_ff[31];

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      last_in      = last_ff;
      fptr_in      = fptr_ff;
      fend_in      = fend_ff;
      fval_in      = fval_ff;
      st_in        = st_ff;
      rd_in        = rd_ff;
      s_in         = s_ff;
      i_in         = i_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      k_in         = k_ff;
      rhsi_in      = rhsi_ff;
      acc_in       = acc_ff;
      dsum_in      = dsum_ff;
      nacc_in      = nacc_ff;
      diag_in      = diag_ff;
      r_in         = r_ff;
      qq_in        = qq_ff;
      v1_in        = 1'b0;
      div_start    = 1'b0;
      hi_c         = hi_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      mat_cmd            = '0;
      mat_cmd.ent_waddr  = count_ff[NZ_W-1:0];
      mat_cmd.ent_wvalue = req_data.value;
      mat_cmd.ent_wcol   = req_data.col_index;
      mat_cmd.ent_raddr  = k_ff[NZ_W-1:0];
      mat_cmd.rs_waddr   = fptr_ff;
      mat_cmd.rs_wdata   = fval_ff;
      mat_cmd.rs_raddr   = i_ff;

      vec_cmd           = '0;
      vec_cmd.waddr     = i_ff;
      vec_cmd.sol_raddr = i_ff;
      vec_cmd.aux_raddr = i_ff;

      // accumulator stage of the product pipeline
      if (v3_ff) begin
         acc_in  = sat_add64(acc_ff, prod_ff);
         dsum_in = d2_ff ? dsum_ff + 48'(a2_ff) : dsum_ff;
      end

      case (state_ff)
         sps_pkg::S_IDLE: begin
            vec_cmd.waddr     = req_data.row_index;
            vec_cmd.wdata     = req_data.value;
            vec_cmd.sol_raddr = req_data.row_index;
            if (accept) begin
               st_in    = sps_pkg::ST_OK;
               rd_in    = '0;
               state_in = sps_pkg::S_RESP;
               case (req_data.func)
                  sps_pkg::FN_LOAD: begin
                     if (!in_range || {1'b0, req_data.col_index} >= n_act) begin
                        st_in = sps_pkg::ST_RANGE;
                     end else if (req_data.row_index < last_ff) begin
                        st_in = sps_pkg::ST_ORDER;
                     end else if (count_ff == CNT_W'(sps_pkg::MAX_NZ)) begin
                        st_in = sps_pkg::ST_FULL;
                     end else begin
                        mat_cmd.ent_we = 1'b1;
                        count_in = count_ff + 1'b1;
                        last_in  = req_data.row_index;
                        if (req_data.row_index > last_ff) begin
                           fptr_in  = last_ff + 1'b1;
                           fend_in  = req_data.row_index;
                           fval_in  = count_ff;
                           state_in = sps_pkg::S_FILL;
                        end
                     end
                  end
                  sps_pkg::FN_WRITE_RHS: begin
                     if (in_range) vec_cmd.rhs_we = 1'b1;
                     else st_in = sps_pkg::ST_RANGE;
                  end
                  sps_pkg::FN_WRITE_SOL: begin
                     if (in_range) vec_cmd.sol_we = 1'b1;
                     else st_in = sps_pkg::ST_RANGE;
                  end
                  sps_pkg::FN_SWEEP: begin
                     s_in     = '0;
                     state_in = sps_pkg::SW_ROW;
                  end
                  sps_pkg::FN_READ_SOL: begin
                     if (in_range) state_in = sps_pkg::S_READ;
                     else st_in = sps_pkg::ST_RANGE;
                  end
                  sps_pkg::FN_CLEAR: begin
                     count_in = '0;
                     last_in  = '0;
                  end
                  default: st_in = sps_pkg::ST_RANGE;
               endcase
            end
         end
         sps_pkg::S_FILL: begin
            // start offsets of the rows opened by this load
            mat_cmd.rs_we = 1'b1;
            fptr_in = fptr_ff + 1'b1;
            if (fptr_ff == fend_ff) state_in = sps_pkg::S_RESP;
         end
         sps_pkg::S_READ: begin
            rd_in    = sol_q;
            state_in = sps_pkg::S_RESP;
         end
         sps_pkg::S_RESP: begin
            if (rsp_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.read_value = rd_ff;
               rsp_data_in.status     = st_ff;
               state_in               = sps_pkg::S_IDLE;
            end
         end
         sps_pkg::SW_ROW: begin
            i_in              = i_sel;
            mat_cmd.rs_raddr  = i_sel;
            vec_cmd.aux_raddr = i_sel;
            state_in          = sps_pkg::SW_LO;
         end
         sps_pkg::SW_LO: begin
            rhsi_in = rhs_q;
            if (i_ff > last_ff) lo_in = count_ff;
            else if (i_ff == '0) lo_in = '0;
            else lo_in = rs_q;
            mat_cmd.rs_raddr = i_ff + 1'b1;
            state_in         = sps_pkg::SW_HI;
         end
         sps_pkg::SW_HI: begin
            hi_c = (i_ff < last_ff) ? rs_q : count_ff;
            if (hi_c > count_ff) hi_c = count_ff;
            hi_in    = hi_c;
            k_in     = (lo_ff > hi_c) ? hi_c : lo_ff;
            acc_in   = '0;
            dsum_in  = '0;
            state_in = sps_pkg::SW_RUN;
         end
         sps_pkg::SW_RUN: begin
            // entry read, then solution read at its column, product, accumulate
            vec_cmd.sol_raddr = ent_col_q;
            if (issue) begin
               v1_in = 1'b1;
               k_in  = k_ff + 1'b1;
            end else if (!v1_ff && !v2_ff && !v3_ff) begin
               state_in = sps_pkg::SW_RES;
            end
         end
         sps_pkg::SW_RES: begin
            nacc_in  = (acc_ff == 64'sh8000_0000_0000_0000) ? 64'sh7FFF_FFFF_FFFF_FFFF
                                                           : -acc_ff;
            diag_in  = sat32(64'(dsum_ff));
            state_in = sps_pkg::SW_DEC;
         end
         sps_pkg::SW_DEC: begin
            r_in     = sat_add64({{16{rhsi_ff[31]}}, rhsi_ff, 16'h0000}, nacc_ff);
            state_in = sps_pkg::SW_ACT;
         end
         sps_pkg::SW_ACT: begin
            if (mode_ff == sps_pkg::MODE_RICH) begin
               qq_in    = sat32(r_ff >>> 16);
               state_in = sps_pkg::SW_MUL;
            end else if (diag_ff == '0) begin
               st_in = sps_pkg::ST_ZERO_DIAG;
               if (mode_ff == sps_pkg::MODE_JACOBI) vec_cmd.corr_we = 1'b1;
               state_in = sps_pkg::SW_NEXT;
            end else begin
               div_start = 1'b1;
               state_in  = sps_pkg::SW_DIV;
            end
         end
         sps_pkg::SW_DIV: begin
            if (div_done) begin
               qq_in = div_q;
               if (mode_ff == sps_pkg::MODE_JACOBI) state_in = sps_pkg::SW_MUL;
               else state_in = sps_pkg::SW_XI;
            end
         end
         sps_pkg::SW_XI: begin
            vec_cmd.sol_we = 1'b1;
            vec_cmd.wdata  = sat32(64'(sol_q) + 64'(qq_ff));
            state_in       = sps_pkg::SW_NEXT;
         end
         sps_pkg::SW_MUL: begin
            state_in = sps_pkg::SW_COR;
         end
         sps_pkg::SW_COR: begin
            vec_cmd.corr_we = 1'b1;
            vec_cmd.wdata   = sat32($signed({{13{t_ff[50]}}, t_ff}) >>> 16);
            state_in        = sps_pkg::SW_NEXT;
         end
         sps_pkg::SW_NEXT: begin
            s_in = s_ff + 1'b1;
            if (s_ff + 1'b1 == n_act) begin
               if (mode_ff == sps_pkg::MODE_RICH || mode_ff == sps_pkg::MODE_JACOBI) begin
                  s_in     = '0;
                  state_in = sps_pkg::SW_UPA;
               end else begin
                  state_in = sps_pkg::S_RESP;
               end
            end else begin
               state_in = sps_pkg::SW_ROW;
            end
         end
         sps_pkg::SW_UPA: begin
            vec_cmd.sol_raddr = s_ff[ROW_W-1:0];
            vec_cmd.aux_raddr = s_ff[ROW_W-1:0];
            state_in          = sps_pkg::SW_UPB;
         end
         sps_pkg::SW_UPB: begin
            vec_cmd.sol_we = 1'b1;
            vec_cmd.waddr  = s_ff[ROW_W-1:0];
            vec_cmd.wdata  = sat32(64'(sol_q) + 64'(corr_q));
            s_in           = s_ff + 1'b1;
            if (s_ff + 1'b1 == n_act) state_in = sps_pkg::S_RESP;
            else state_in = sps_pkg::SW_UPA;
         end
         default: state_in = sps_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sps_pkg::S_IDLE;
         count_ff     <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
         v1_ff        <= v1_in;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      fptr_ff     <= fptr_in;
      fend_ff     <= fend_in;
      fval_ff     <= fval_in;
      st_ff       <= st_in;
      rd_ff       <= rd_in;
      rsp_data_ff <= rsp_data_in;
      s_ff        <= s_in;
      i_ff        <= i_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      k_ff        <= k_in;
      rhsi_ff     <= rhsi_in;
      acc_ff      <= acc_in;
      dsum_ff     <= dsum_in;
      nacc_ff     <= nacc_in;
      diag_ff     <= diag_in;
      r_ff        <= r_in;
      qq_ff       <= qq_in;
      a1_ff       <= ent_value_q;
      d1_ff       <= (ent_col_q == i_ff);
      a2_ff       <= a1_ff;
      d2_ff       <= d1_ff;
      prod_ff     <= a1_ff * sol_q;
      t_ff        <= $signed({1'b0, damp_ff}) * qq_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(sps_pkg::MAX_NZ))
      else $error("nonzero count beyond store depth");

   a_no_accept_clearing: assert property (@(posedge clock) disable iff (reset)
      vec_busy |-> !accept)
      else $error("transaction taken during vector clearing pass");

   a_sweep_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.func == sps_pkg::FN_SWEEP) |=> state_ff == sps_pkg::SW_ROW)
      else $error("sweep did not start");

   a_div_start_state: assert property (@(posedge clock) disable iff (reset)
      div_start |-> (state_ff == sps_pkg::SW_ACT && diag_ff != '0))
      else $error("divider started outside of a row with nonzero diagonal");
`endif

endmodule
